@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers; they compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// cond holds at every clock edge out of reset
`define LBE_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// cons holds in the cycle after ante
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LBE_ASSERT_ALWAYS(lbl, cond, msg)
`define LBE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/lbe_pkg.sv @@
// ---------------------------------------------------------------------------
// lbe_pkg
// Shared types, constants and byte arithmetic of the LRU byte budget evictor.
// ---------------------------------------------------------------------------
package lbe_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int BYTE_BITS     = 40;
  localparam int HANDLE_W      = 32;
  localparam int RANK_W        = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int MARK_W        = 10;
  localparam int LVL_W         = BYTE_BITS + 4;
  localparam int PROD_W        = BYTE_BITS + MARK_W;
  // divide by 1000 runs one 10-bit digit per cycle
  localparam int DIV_STEPS     = PROD_W / MARK_W;
  localparam int DCNT_W        = $clog2(DIV_STEPS + 1);
  // ceil(2^30 / 1000); exact quotient for any 20-bit partial remainder
  localparam int RECIP_W       = 21;
  localparam int RECIP_SH      = 30;
  localparam int CFG_IDX_W     = 3;

  localparam logic [MARK_W-1:0]  MARK_FULL = MARK_W'(1000);
  localparam logic [RECIP_W-1:0] RECIP_1K  = RECIP_W'(1073742);

  typedef enum logic [2:0] {
    REQ_REGISTER   = 3'd0,
    REQ_UNREGISTER = 3'd1,
    REQ_ACCESS     = 3'd2,
    REQ_PERSIST    = 3'd3,
    REQ_ENSURE     = 3'd4,
    REQ_EVICT      = 3'd5,
    REQ_SET_AVAIL  = 3'd6,
    REQ_CAN_ALLOC  = 3'd7
  } lbe_req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2,
    ST_DENIED  = 2'd3
  } lbe_status_t;

  typedef enum logic [2:0] {
    CFG_TOTAL     = 3'd0,
    CFG_INIT_USED = 3'd1,
    CFG_AUTO      = 3'd2,
    CFG_MIN_EVICT = 3'd3,
    CFG_MAX_EVICT = 3'd4,
    CFG_HIGH_MARK = 3'd5,
    CFG_LOW_MARK  = 3'd6
  } lbe_cfg_idx_t;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_KILL  = 3'd1,
    OP_TOUCH = 3'd2,
    OP_PIN   = 3'd3,
    OP_ALLOC = 3'd4
  } lbe_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    lbe_op_t               op;
    logic                  by_rank;
    logic [HANDLE_W-1:0]   key_handle;
    logic [RANK_W-1:0]     key_rank;
    logic [RANK_W-1:0]     new_rank;
    logic [HANDLE_W-1:0]   new_handle;
    logic [BYTE_BITS-1:0]  new_size;
    logic                  new_pin;
    logic                  wr_data;
  } lbe_cmd_t;

  // passed from cell to cell along the row
  typedef struct packed {
    logic                  free_seen;
    logic                  hit;
    logic [RANK_W-1:0]     hit_rank;
    logic [BYTE_BITS-1:0]  hit_size;
    logic [HANDLE_W-1:0]   hit_handle;
    logic                  hit_pin;
  } lbe_chain_t;

  function automatic logic [BYTE_BITS-1:0] sat_add(input logic [BYTE_BITS-1:0] a,
                                                   input logic [BYTE_BITS-1:0] b);
    logic [BYTE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTE_BITS] ? {BYTE_BITS{1'b1}} : s[BYTE_BITS-1:0];
  endfunction

  function automatic logic [BYTE_BITS-1:0] sat_sub(input logic [BYTE_BITS-1:0] a,
                                                   input logic [BYTE_BITS-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [BYTE_BITS-1:0] clamp(input logic [BYTE_BITS-1:0] t,
                                                 input logic [BYTE_BITS-1:0] mn,
                                                 input logic [BYTE_BITS-1:0] mx);
    logic [BYTE_BITS-1:0] v;
    v = (t < mn) ? mn : t;
    return (v > mx) ? mx : v;
  endfunction

endpackage

@@ rtl/lbe_cell.sv @@
// ---------------------------------------------------------------------------
// lbe_cell
// One table entry: handle, size, pin and recency rank, with its chain link.
// ---------------------------------------------------------------------------
module lbe_cell import lbe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lbe_cmd_t   cmd,
  input  lbe_chain_t chain_in,
  output lbe_chain_t chain_out
);

  logic                 valid_r, valid_nxt;
  logic [HANDLE_W-1:0]  handle_r, handle_nxt;
  logic [BYTE_BITS-1:0] size_r, size_nxt;
  logic                 pin_r, pin_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;

  logic sel_r, sel_h, sel, above, alloc_me;

  assign sel_r    = valid_r && (rank_r == cmd.key_rank);
  assign sel_h    = valid_r && (handle_r == cmd.key_handle);
  assign sel      = cmd.by_rank ? sel_r : sel_h;
  assign above    = valid_r && (rank_r > cmd.key_rank);
  assign alloc_me = (cmd.op == OP_ALLOC) && !valid_r && !chain_in.free_seen;

  always_comb begin
    chain_out.free_seen  = chain_in.free_seen | !valid_r;
    chain_out.hit        = chain_in.hit | sel;
    chain_out.hit_rank   = chain_in.hit_rank   | (sel ? rank_r   : '0);
    chain_out.hit_size   = chain_in.hit_size   | (sel ? size_r   : '0);
    chain_out.hit_handle = chain_in.hit_handle | (sel ? handle_r : '0);
    chain_out.hit_pin    = chain_in.hit_pin    | (sel & pin_r);
  end

  always_comb begin
    valid_nxt  = valid_r;
    handle_nxt = handle_r;
    size_nxt   = size_r;
    pin_nxt    = pin_r;
    rank_nxt   = rank_r;
    case (cmd.op)
      OP_KILL: begin
        if (sel_r) valid_nxt = 1'b0;
        else if (above) rank_nxt = rank_r - 1'b1;
      end
      OP_TOUCH: begin
        if (sel_r) begin
          rank_nxt = cmd.new_rank;
          if (cmd.wr_data) begin
            size_nxt = cmd.new_size;
            pin_nxt  = cmd.new_pin;
          end
        end else if (above) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      OP_PIN: begin
        if (sel_r) pin_nxt = cmd.new_pin;
      end
      OP_ALLOC: begin
        if (alloc_me) begin
          valid_nxt  = 1'b1;
          handle_nxt = cmd.new_handle;
          size_nxt   = cmd.new_size;
          pin_nxt    = cmd.new_pin;
          rank_nxt   = cmd.new_rank;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    handle_r <= handle_nxt;
    size_r   <= size_nxt;
    pin_r    <= pin_nxt;
    rank_r   <= rank_nxt;
  end

endmodule

@@ rtl/lbe_ctrl.sv @@
// ---------------------------------------------------------------------------
// lbe_ctrl
// Request sequencer: lookups, byte counters, pressure check, eviction scan.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lbe_ctrl import lbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_req_type,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic [BYTE_BITS-1:0]  in_size_bytes,
  input  logic                  in_persistent_flag,
  input  logic [BYTE_BITS-1:0]  in_amount_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic                  out_is_eviction,
  output logic [HANDLE_W-1:0]   out_evicted_handle,
  output logic [BYTE_BITS-1:0]  out_freed_bytes,
  output logic                  out_granted,
  output logic [BYTE_BITS-1:0]  out_used_now,
  output logic [1:0]            out_pressure_level,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_BITS-1:0]  cfg_wdata,
  output lbe_cmd_t              cmd,
  input  lbe_chain_t            chain
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_LOOK  = 11'b00000000010,
    S_EXEC  = 11'b00000000100,
    S_PR0   = 11'b00000001000,
    S_PR1   = 11'b00000010000,
    S_DIV   = 11'b00000100000,
    S_SCAN  = 11'b00001000000,
    S_EVICT = 11'b00010000000,
    S_EMIT  = 11'b00100000000,
    S_CAN   = 11'b01000000000,
    S_FINAL = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [BYTE_BITS-1:0] total_r, total_nxt, init_used_r, init_used_nxt;
  logic [BYTE_BITS-1:0] min_ev_r, min_ev_nxt, max_ev_r, max_ev_nxt;
  logic                 auto_r, auto_nxt;
  logic [MARK_W-1:0]    hi_r, hi_nxt, lo_r, lo_nxt;

  // control state
  logic [BYTE_BITS-1:0] used_r, used_nxt;
  logic [1:0]           pstate_r, pstate_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // request payload
  lbe_req_t             req_r, req_nxt;
  logic [HANDLE_W-1:0]  hnd_r, hnd_nxt;
  logic [BYTE_BITS-1:0] size_r, size_nxt, amt_r, amt_nxt;
  logic                 pin_r, pin_nxt;
  logic                 found_r, found_nxt, free_ok_r, free_ok_nxt;
  logic [RANK_W-1:0]    frank_r, frank_nxt;
  logic [BYTE_BITS-1:0] fsize_r, fsize_nxt;
  logic [BYTE_BITS-1:0] freed_r, freed_nxt, target_r, target_nxt, acc_r, acc_nxt;
  logic                 granted_r, granted_nxt;
  lbe_status_t          st_r, st_nxt;
  logic [CNT_W-1:0]     r_r, r_nxt;
  logic [HANDLE_W-1:0]  evh_r, evh_nxt;
  logic [BYTE_BITS-1:0] evs_r, evs_nxt;
  logic [LVL_W-1:0]     u10_r, u10_nxt, t9_r, t9_nxt, t8_r, t8_nxt, t6_r, t6_nxt;
  logic [PROD_W-1:0]    u1k_r, u1k_nxt, thi_r, thi_nxt, quot_r, quot_nxt;
  logic [MARK_W-1:0]    rem_r, rem_nxt;
  logic [DCNT_W-1:0]    dcnt_r, dcnt_nxt;

  // result word
  logic [1:0]           o_st_r, o_st_nxt;
  logic                 o_ev_r, o_ev_nxt, o_gr_r, o_gr_nxt, o_last_r, o_last_nxt;
  logic [HANDLE_W-1:0]  o_h_r, o_h_nxt;
  logic [BYTE_BITS-1:0] o_fr_r, o_fr_nxt, o_used_r, o_used_nxt;
  logic [1:0]           o_pl_r, o_pl_nxt;

  logic                 slot_free, accept, ens_ok;
  logic [BYTE_BITS-1:0] avail, acc_sum;
  logic [MARK_W-1:0]    hi_c, lo_c;
  logic [1:0]           lvl;
  logic [2*MARK_W-1:0]  rem_sh, rem_left;
  logic [RECIP_W+2*MARK_W-1:0] dprod;
  logic [MARK_W-1:0]    qdig;

  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign avail     = sat_sub(total_r, used_r);
  assign ens_ok    = (avail >= amt_r);
  assign hi_c      = (hi_r > MARK_FULL) ? MARK_FULL : hi_r;
  assign lo_c      = (lo_r > MARK_FULL) ? MARK_FULL : lo_r;
  assign acc_sum   = sat_add(acc_r, chain.hit_size);
  // partial remainder with the next 10-bit dividend digit; quotient digit by reciprocal
  assign rem_sh    = {rem_r, quot_r[PROD_W-1 -: MARK_W]};
  assign dprod     = (RECIP_W+2*MARK_W)'(rem_sh) * (RECIP_W+2*MARK_W)'(RECIP_1K);
  assign qdig      = dprod[RECIP_SH +: MARK_W];
  assign rem_left  = rem_sh - (2*MARK_W)'(qdig) * (2*MARK_W)'(MARK_FULL);

  always_comb begin
    if (u10_r >= t9_r)      lvl = 2'd3;
    else if (u10_r >= t8_r) lvl = 2'd2;
    else if (u10_r >= t6_r) lvl = 2'd1;
    else                    lvl = 2'd0;
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    init_used_nxt = init_used_r;
    min_ev_nxt    = min_ev_r;
    max_ev_nxt    = max_ev_r;
    auto_nxt      = auto_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    used_nxt      = used_r;
    pstate_nxt    = pstate_r;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    hnd_nxt       = hnd_r;
    size_nxt      = size_r;
    amt_nxt       = amt_r;
    pin_nxt       = pin_r;
    found_nxt     = found_r;
    free_ok_nxt   = free_ok_r;
    frank_nxt     = frank_r;
    fsize_nxt     = fsize_r;
    freed_nxt     = freed_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    granted_nxt   = granted_r;
    st_nxt        = st_r;
    r_nxt         = r_r;
    evh_nxt       = evh_r;
    evs_nxt       = evs_r;
    u10_nxt       = u10_r;
    t9_nxt        = t9_r;
    t8_nxt        = t8_r;
    t6_nxt        = t6_r;
    u1k_nxt       = u1k_r;
    thi_nxt       = thi_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    o_st_nxt      = o_st_r;
    o_ev_nxt      = o_ev_r;
    o_gr_nxt      = o_gr_r;
    o_last_nxt    = o_last_r;
    o_h_nxt       = o_h_r;
    o_fr_nxt      = o_fr_r;
    o_used_nxt    = o_used_r;
    o_pl_nxt      = o_pl_r;
    out_valid_nxt = out_valid_r && out_stall;

    cmd            = '0;
    cmd.op         = OP_NOP;
    cmd.key_handle = hnd_r;
    cmd.key_rank   = frank_r;
    cmd.new_handle = hnd_r;
    cmd.new_size   = size_r;
    cmd.new_pin    = pin_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt     = lbe_req_t'(in_req_type);
          hnd_nxt     = in_handle;
          size_nxt    = in_size_bytes;
          pin_nxt     = in_persistent_flag;
          amt_nxt     = in_amount_bytes;
          freed_nxt   = '0;
          granted_nxt = 1'b0;
          st_nxt      = ST_OK;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        found_nxt   = chain.hit;
        frank_nxt   = chain.hit_rank;
        fsize_nxt   = chain.hit_size;
        free_ok_nxt = chain.free_seen;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_FINAL;
        case (req_r)
          REQ_REGISTER: begin
            if (found_r) begin
              cmd.op       = OP_TOUCH;
              cmd.new_rank = RANK_W'(cnt_r - 1'b1);
              cmd.wr_data  = 1'b1;
              used_nxt     = sat_add(sat_sub(used_r, fsize_r), size_r);
              state_nxt    = S_PR0;
            end else if (free_ok_r) begin
              cmd.op       = OP_ALLOC;
              cmd.new_rank = RANK_W'(cnt_r);
              cnt_nxt      = cnt_r + 1'b1;
              used_nxt     = sat_add(used_r, size_r);
              state_nxt    = S_PR0;
            end else begin
              st_nxt = ST_FULL;
            end
          end
          REQ_UNREGISTER: begin
            if (found_r) begin
              cmd.op   = OP_KILL;
              cnt_nxt  = cnt_r - 1'b1;
              used_nxt = sat_sub(used_r, fsize_r);
            end else begin
              st_nxt = ST_UNKNOWN;
            end
          end
          REQ_ACCESS: begin
            if (found_r) begin
              cmd.op       = OP_TOUCH;
              cmd.new_rank = RANK_W'(cnt_r - 1'b1);
            end else begin
              st_nxt = ST_UNKNOWN;
            end
          end
          REQ_PERSIST: begin
            if (found_r) cmd.op = OP_PIN;
            else st_nxt = ST_UNKNOWN;
          end
          REQ_ENSURE: begin
            if (!ens_ok && auto_r) begin
              target_nxt = clamp(amt_r - avail, min_ev_r, max_ev_r);
              r_nxt      = '0;
              state_nxt  = S_SCAN;
            end
          end
          REQ_EVICT: begin
            target_nxt = amt_r;
            r_nxt      = '0;
            state_nxt  = S_SCAN;
          end
          REQ_SET_AVAIL: begin
            used_nxt  = sat_sub(total_r, amt_r);
            state_nxt = S_PR0;
          end
          default: begin
            if (ens_ok) begin
              granted_nxt = 1'b1;
            end else if (auto_r) begin
              acc_nxt   = avail;
              r_nxt     = '0;
              state_nxt = S_CAN;
            end
          end
        endcase
      end
      S_PR0: begin
        if (total_r == '0) begin
          state_nxt = S_FINAL;
        end else begin
          u10_nxt  = LVL_W'(used_r) * LVL_W'(10);
          t9_nxt   = LVL_W'(total_r) * LVL_W'(9);
          t8_nxt   = LVL_W'(total_r) * LVL_W'(8);
          t6_nxt   = LVL_W'(total_r) * LVL_W'(6);
          u1k_nxt  = PROD_W'(used_r) * PROD_W'(1000);
          thi_nxt  = PROD_W'(total_r) * PROD_W'(hi_c);
          quot_nxt = PROD_W'(total_r) * PROD_W'(lo_c);
          state_nxt = S_PR1;
        end
      end
      S_PR1: begin
        state_nxt = S_FINAL;
        if (lvl != pstate_r) begin
          pstate_nxt = lvl;
          if (auto_r && lvl[1] && (u1k_r >= thi_r)) begin
            rem_nxt   = '0;
            dcnt_nxt  = DCNT_W'(DIV_STEPS);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        // long divide of total*low_mark by 1000, one 10-bit digit a cycle
        if (dcnt_r == '0) begin
          target_nxt = clamp(sat_sub(used_r, quot_r[BYTE_BITS-1:0]), min_ev_r, max_ev_r);
          r_nxt      = '0;
          state_nxt  = S_SCAN;
        end else begin
          quot_nxt = {quot_r[PROD_W-MARK_W-1:0], qdig};
          rem_nxt  = rem_left[MARK_W-1:0];
          dcnt_nxt = dcnt_r - 1'b1;
        end
      end
      S_SCAN: begin
        // ranks only shift down after a kill, so the walk never restarts
        cmd.by_rank  = 1'b1;
        cmd.key_rank = r_r[RANK_W-1:0];
        if ((freed_r >= target_r) || (r_r == cnt_r)) begin
          state_nxt = S_FINAL;
        end else if (chain.hit && !chain.hit_pin) begin
          evh_nxt   = chain.hit_handle;
          evs_nxt   = chain.hit_size;
          state_nxt = S_EVICT;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      S_EVICT: begin
        cmd.op       = OP_KILL;
        cmd.key_rank = r_r[RANK_W-1:0];
        cnt_nxt      = cnt_r - 1'b1;
        used_nxt     = sat_sub(used_r, evs_r);
        freed_nxt    = sat_add(freed_r, evs_r);
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_st_nxt      = ST_OK;
          o_ev_nxt      = 1'b1;
          o_h_nxt       = evh_r;
          o_fr_nxt      = freed_r;
          o_gr_nxt      = 1'b0;
          o_used_nxt    = used_r;
          o_pl_nxt      = pstate_r;
          o_last_nxt    = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_CAN: begin
        cmd.by_rank  = 1'b1;
        cmd.key_rank = r_r[RANK_W-1:0];
        if (granted_r || (r_r == cnt_r)) begin
          state_nxt = S_FINAL;
        end else begin
          if (chain.hit && !chain.hit_pin) begin
            acc_nxt = acc_sum;
            if (acc_sum >= amt_r) granted_nxt = 1'b1;
          end
          r_nxt = r_r + 1'b1;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_ev_nxt      = 1'b0;
          o_h_nxt       = '0;
          o_fr_nxt      = freed_r;
          o_used_nxt    = used_r;
          o_pl_nxt      = pstate_r;
          o_last_nxt    = 1'b1;
          if (req_r == REQ_ENSURE) begin
            o_gr_nxt = ens_ok;
            o_st_nxt = ens_ok ? ST_OK : ST_DENIED;
          end else if (req_r == REQ_CAN_ALLOC) begin
            o_gr_nxt = granted_r;
            o_st_nxt = granted_r ? ST_OK : ST_DENIED;
          end else begin
            o_gr_nxt = 1'b0;
            o_st_nxt = st_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (lbe_cfg_idx_t'(cfg_index))
        CFG_TOTAL:     total_nxt = cfg_wdata;
        CFG_INIT_USED: begin
          init_used_nxt = cfg_wdata;
          used_nxt      = cfg_wdata;
        end
        CFG_AUTO:      auto_nxt   = cfg_wdata[0];
        CFG_MIN_EVICT: min_ev_nxt = cfg_wdata;
        CFG_MAX_EVICT: max_ev_nxt = cfg_wdata;
        CFG_HIGH_MARK: hi_nxt     = cfg_wdata[MARK_W-1:0];
        CFG_LOW_MARK:  lo_nxt     = cfg_wdata[MARK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      init_used_r <= '0;
      min_ev_r    <= '0;
      max_ev_r    <= '1;
      auto_r      <= 1'b1;
      hi_r        <= MARK_W'(850);
      lo_r        <= MARK_W'(700);
      used_r      <= '0;
      pstate_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      init_used_r <= init_used_nxt;
      min_ev_r    <= min_ev_nxt;
      max_ev_r    <= max_ev_nxt;
      auto_r      <= auto_nxt;
      hi_r        <= hi_nxt;
      lo_r        <= lo_nxt;
      used_r      <= used_nxt;
      pstate_r    <= pstate_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    hnd_r     <= hnd_nxt;
    size_r    <= size_nxt;
    amt_r     <= amt_nxt;
    pin_r     <= pin_nxt;
    found_r   <= found_nxt;
    free_ok_r <= free_ok_nxt;
    frank_r   <= frank_nxt;
    fsize_r   <= fsize_nxt;
    freed_r   <= freed_nxt;
    target_r  <= target_nxt;
    acc_r     <= acc_nxt;
    granted_r <= granted_nxt;
    st_r      <= st_nxt;
    r_r       <= r_nxt;
    evh_r     <= evh_nxt;
    evs_r     <= evs_nxt;
    u10_r     <= u10_nxt;
    t9_r      <= t9_nxt;
    t8_r      <= t8_nxt;
    t6_r      <= t6_nxt;
    u1k_r     <= u1k_nxt;
    thi_r     <= thi_nxt;
    quot_r    <= quot_nxt;
    rem_r     <= rem_nxt;
    dcnt_r    <= dcnt_nxt;
    o_st_r    <= o_st_nxt;
    o_ev_r    <= o_ev_nxt;
    o_gr_r    <= o_gr_nxt;
    o_last_r  <= o_last_nxt;
    o_h_r     <= o_h_nxt;
    o_fr_r    <= o_fr_nxt;
    o_used_r  <= o_used_nxt;
    o_pl_r    <= o_pl_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = o_st_r;
  assign out_is_eviction    = o_ev_r;
  assign out_evicted_handle = o_h_r;
  assign out_freed_bytes    = o_fr_r;
  assign out_granted        = o_gr_r;
  assign out_used_now       = o_used_r;
  assign out_pressure_level = o_pl_r;
  assign out_last           = o_last_r;

  `LBE_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(TABLE_ENTRIES), "entry count overflow")
  `LBE_ASSERT_ALWAYS(a_scan_bound, (state_r != S_SCAN) || (r_r <= cnt_r), "scan past count")
  `LBE_ASSERT_NEXT(a_evict_cnt, state_r == S_EVICT, (cnt_r + 1'b1) == $past(cnt_r), "evict count")
  `LBE_ASSERT_NEXT(a_emit_load, (state_r == S_EMIT) && slot_free, out_valid_r && !out_last, "emit")

endmodule

@@ rtl/lru_byte_budget_evictor.sv @@
// ---------------------------------------------------------------------------
// lru_byte_budget_evictor
// LRU allocation table with a used-byte budget and pressure cleanup.
// ---------------------------------------------------------------------------
// One request at a time. Table lookups go through the cell row and are
// registered in S_LOOK; simple requests then pass S_EXEC and S_FINAL, where
// they wait for the output. A pressure check runs S_PR0 and S_PR1, and a
// cleanup adds a divide by 1000 (five 10-bit digits, one a cycle). An eviction
// pass walks the recency ranks one per cycle while it evicts nothing; each
// evicted entry passes S_EVICT and S_EMIT, which waits for the output. A
// can-allocate look-ahead walks at most one rank per stored entry. Each evicted
// entry is reported as its own word, and every request ends with one word marked last.
module lru_byte_budget_evictor import lbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_req_type,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic [BYTE_BITS-1:0]  in_size_bytes,
  input  logic                  in_persistent_flag,
  input  logic [BYTE_BITS-1:0]  in_amount_bytes,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic                  out_is_eviction,
  output logic [HANDLE_W-1:0]   out_evicted_handle,
  output logic [BYTE_BITS-1:0]  out_freed_bytes,
  output logic                  out_granted,
  output logic [BYTE_BITS-1:0]  out_used_now,
  output logic [1:0]            out_pressure_level,
  output logic                  out_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_BITS-1:0]  cfg_wdata
);

  lbe_cmd_t   cmd;
  lbe_chain_t chain [TABLE_ENTRIES+1];

  assign chain[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    lbe_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1])
    );
  end

  lbe_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_handle          (in_handle),
    .in_size_bytes      (in_size_bytes),
    .in_persistent_flag (in_persistent_flag),
    .in_amount_bytes    (in_amount_bytes),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_is_eviction    (out_is_eviction),
    .out_evicted_handle (out_evicted_handle),
    .out_freed_bytes    (out_freed_bytes),
    .out_granted        (out_granted),
    .out_used_now       (out_used_now),
    .out_pressure_level (out_pressure_level),
    .out_last           (out_last),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .chain              (chain[TABLE_ENTRIES])
  );

endmodule
